// ===== design/sgns_pkg.sv =====
// Shared constants, command codes and the sigmoid table builder for the
// skip-gram negative-sampling update block. No dependencies.
package sgns_pkg;

   localparam int DIM         = 128;
   localparam int ELEM_W      = $clog2(DIM);
   localparam int CNT_W       = $clog2(DIM + 1);
   localparam int ROW_W       = 16;
   localparam int ADDR_W      = ROW_W + ELEM_W;
   localparam int CLAMP_RANGE = 6;
   localparam int SIG_N       = 1024;
   localparam int SIG_W       = $clog2(SIG_N);

   // Table index = floor((f + C) / (2C * 2^24 / N)); with the defaults the
   // divisor is 12 * 2^14: drop 14 bits, then divide by 12 via reciprocal.
   localparam int SIG_PRE_SH   = 14;
   localparam int SIG_V_W      = 14;
   localparam int SIG_DIV      = 2 * CLAMP_RANGE * (2 ** 24) / SIG_N / (2 ** SIG_PRE_SH);
   localparam int SIG_RCP_SH   = 20;
   localparam int SIG_RCP      = ((2 ** SIG_RCP_SH) + SIG_DIV - 1) / SIG_DIV;
   localparam int SIG_RCP_W    = $clog2(SIG_RCP + 1);
   localparam longint CLAMP_Q24 = longint'(CLAMP_RANGE) <<< 24;

   typedef enum logic [1:0] {
      CMD_WR_IN  = 2'd0,
      CMD_WR_OUT = 2'd1,
      CMD_RD_IN  = 2'd2,
      CMD_TRAIN  = 2'd3
   } cmd_type;

   typedef logic [15:0] sig_table_type [SIG_N];

   // restoring long division, elaboration use only
   function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], a[i]};
         if (r >= {1'b0, b}) begin
            r    = r - {1'b0, b};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // e^-y for y in [0, 1], Q2.30, Taylor series through the 20th-order term
   function automatic logic [63:0] exp_neg_unit(input logic [63:0] y);
      logic [63:0] term;
      longint      sum;
      term = 64'd1 << 30;
      sum  = longint'(1) <<< 30;
      for (int n = 1; n <= 20; n++) begin
         term = udiv64((term * y) >> 30, 64'(n));
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      return (sum < 0) ? 64'd0 : 64'(sum);
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      logic [63:0]   e1;
      logic [63:0]   ad;
      logic [63:0]   a;
      logic [63:0]   k;
      logic [63:0]   t;
      logic [63:0]   num;
      logic [63:0]   den;
      logic [63:0]   s;
      longint        d;
      e1 = exp_neg_unit(64'd1 << 30);
      for (int i = 0; i < SIG_N; i++) begin
         d  = 2 * longint'(i) - longint'(SIG_N);
         ad = (d < 0) ? 64'(-d) : 64'(d);
         a  = udiv64((ad * 64'(CLAMP_RANGE)) << 30, 64'(SIG_N));
         k  = a >> 30;
         t  = exp_neg_unit(a & ((64'd1 << 30) - 64'd1));
         for (logic [63:0] j = 0; j < k; j++) begin
            t = (t * e1) >> 30;
         end
         den = (64'd1 << 30) + t;
         num = (d >= 0) ? (64'd1 << 30) : t;
         s   = udiv64((num << 16) + (den >> 1), den);
         tbl[i] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
      end
      return tbl;
   endfunction

endpackage

// ===== design/sgns_sig_rom.sv =====
// Sigmoid lookup ROM with a registered read port.
// Depends on sgns_pkg for the table contents and index width.
module sgns_sig_rom (
   input  logic                       clock,
   input  logic [sgns_pkg::SIG_W-1:0] addr,
   output logic [15:0]                data_ff
);

   localparam sgns_pkg::sig_table_type SIG_TABLE = sgns_pkg::build_sig_table();

   always_ff @(posedge clock) begin
      data_ff <= SIG_TABLE[addr];
   end

endmodule

// ===== design/skipgram_negative_sampling_update_top.sv =====
// Top level of the skip-gram negative-sampling update block: embedding
// memories, error accumulator, train sequencer. Uses sgns_pkg, sgns_sig_rom.
//
//   channel   ports              handshake
//   request   start/busy, req_*  taken when start && !busy
//   response  rsp_*              rsp_valid strobe, one cycle, no backpressure
//   config    csr_*              csr_valid && csr_ready, ready always high
//
// Element writes never raise busy and may follow back to back; a read holds busy in S_RD.
// Train keeps busy high through the dot pass, the sigmoid and gradient states and
// the update pass over n = min(dim_used, 128) elements: one memory port per table gives
// one element per cycle in both passes. The strobe comes as busy goes low.
// Reset clears control and the accumulator valid bits; embeddings stay as-is.
// busy stays high from a read or train request until its response strobe.
module skipgram_negative_sampling_update_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [15:0]        req_context_word,
   input  logic [15:0]        req_target_word,
   input  logic [6:0]         req_element,
   input  logic signed [15:0] req_value,
   input  logic               req_label,
   input  logic [15:0]        req_learning_rate,
   input  logic               req_last_target,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_read_value,
   output logic [15:0]        rsp_score,
   output logic               rsp_error_applied,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);

   localparam int EW = sgns_pkg::ELEM_W;
   localparam int CW = sgns_pkg::CNT_W;
   localparam int AW = sgns_pkg::ADDR_W;
   localparam int RW = sgns_pkg::ROW_W;
   localparam logic signed [39:0] CLAMP_F = 40'(sgns_pkg::CLAMP_Q24);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_RD    = 10'b0000000010,
      S_DOT   = 10'b0000000100,
      S_SIG1  = 10'b0000001000,
      S_SIG2  = 10'b0000010000,
      S_SIG3  = 10'b0000100000,
      S_GRAD1 = 10'b0001000000,
      S_GRAD2 = 10'b0010000000,
      S_UPD   = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    dim_used_ff;

   // request latches
   logic [RW-1:0] ctx_ff, tgt_ff;
   logic          label_ff, last_ff;
   logic [15:0]   lr_ff;
   logic [CW-1:0] n_ff;

   // memories
   logic [15:0] in_mem  [2**AW];
   logic [15:0] out_mem [2**AW];
   logic [31:0] err_mem [sgns_pkg::DIM];
   logic [sgns_pkg::DIM-1:0] err_vld_ff;

   logic [AW-1:0] in_raddr, out_raddr, in_waddr, out_waddr;
   logic          in_we, out_we, err_we;
   logic [15:0]   in_wdata, out_wdata;
   logic signed [15:0] in_q_ff, out_q_ff;
   logic [31:0]   err_q_ff;
   logic          err_v_q_ff;

   // pipelines
   logic          issue, d1_ff, d2_ff, u1_ff, u2_ff, u3_ff;
   logic [EW-1:0] i1_ff, i2_ff, i3_ff;
   logic signed [31:0] prod_ff;
   logic signed [39:0] acc_ff;
   logic          hi_ff, lo_ff;
   logic [sgns_pkg::SIG_V_W-1:0] v_ff;
   logic [sgns_pkg::SIG_W-1:0]   idx_ff;
   logic [15:0]   rom_q_ff;
   logic [16:0]   sig_ff, sig_val;
   logic signed [17:0] diff;
   logic signed [34:0] gprod_ff, gsum;
   logic signed [17:0] g_ff;
   logic signed [33:0] ge_ff, gx_ff, ge_r, gx_r;
   logic signed [15:0] x2_ff, o2_ff, x3_ff;
   logic signed [31:0] e2_ff, enew, enew3_ff;
   logic signed [32:0] esum, e3r;
   logic signed [18:0] osum;
   logic signed [29:0] isum;
   logic signed [15:0] onew, inew;
   logic [sgns_pkg::SIG_V_W+sgns_pkg::SIG_RCP_W-1:0] mprod;
   logic [sgns_pkg::SIG_V_W+sgns_pkg::SIG_RCP_W-sgns_pkg::SIG_RCP_SH-1:0] mq;
   logic signed [39:0] ushift;

   logic rsp_valid_ff, rsp_applied_ff;
   logic signed [15:0] rsp_rd_ff;
   logic [15:0] rsp_score_ff;

   logic accept;
   sgns_pkg::cmd_type cmd;

   assign cmd       = sgns_pkg::cmd_type'(req_cmd);
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rsp_rd_ff;
   assign rsp_score         = rsp_score_ff;
   assign rsp_error_applied = rsp_applied_ff;

   sgns_sig_rom u_rom (
      .clock   (clock),
      .addr    (idx_ff),
      .data_ff (rom_q_ff)
   );

   assign issue = ((state_ff == S_DOT) || (state_ff == S_UPD)) && (cnt_ff < n_ff);

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (issue) cnt_in = cnt_ff + 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept && cmd == sgns_pkg::CMD_RD_IN) state_in = S_RD;
            if (accept && cmd == sgns_pkg::CMD_TRAIN) state_in = S_DOT;
         end
         S_RD:    state_in = S_IDLE;
         S_DOT:   if (cnt_ff == n_ff && !d1_ff && !d2_ff) state_in = S_SIG1;
         S_SIG1:  state_in = S_SIG2;
         S_SIG2:  state_in = S_SIG3;
         S_SIG3:  state_in = S_GRAD1;
         S_GRAD1: state_in = S_GRAD2;
         S_GRAD2: begin
            state_in = S_UPD;
            cnt_in   = '0;
         end
         S_UPD:   if (cnt_ff == n_ff && !u1_ff && !u2_ff && !u3_ff) state_in = S_FIN;
         S_FIN:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dim_used_ff  <= 8'd128;
         d1_ff        <= 1'b0;
         d2_ff        <= 1'b0;
         u1_ff        <= 1'b0;
         u2_ff        <= 1'b0;
         u3_ff        <= 1'b0;
         err_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         if (csr_valid && csr_ready) dim_used_ff <= csr_data;
         d1_ff        <= issue && (state_ff == S_DOT);
         d2_ff        <= d1_ff;
         u1_ff        <= issue && (state_ff == S_UPD);
         u2_ff        <= u1_ff;
         u3_ff        <= u2_ff && last_ff;
         if (state_ff == S_FIN && last_ff) begin
            err_vld_ff <= '0;
         end else if (err_we) begin
            err_vld_ff[i2_ff] <= 1'b1;
         end
         rsp_valid_ff <= (accept && (cmd == sgns_pkg::CMD_WR_IN || cmd == sgns_pkg::CMD_WR_OUT))
                         || (state_ff == S_RD) || (state_ff == S_FIN);
      end
   end

   // ---------------- memory ports ----------------
   always_comb begin
      if (state_ff == S_IDLE) begin
         in_raddr = {req_context_word, req_element};
      end else begin
         in_raddr = {ctx_ff, cnt_ff[EW-1:0]};
      end
      out_raddr = {tgt_ff, cnt_ff[EW-1:0]};

      in_we    = 1'b0;
      in_waddr = {req_context_word, req_element};
      in_wdata = req_value;
      if (accept && cmd == sgns_pkg::CMD_WR_IN) begin
         in_we = 1'b1;
      end else if (u3_ff) begin
         in_we    = 1'b1;
         in_waddr = {ctx_ff, i3_ff};
         in_wdata = inew;
      end

      out_we    = 1'b0;
      out_waddr = {req_target_word, req_element};
      out_wdata = req_value;
      if (accept && cmd == sgns_pkg::CMD_WR_OUT) begin
         out_we = 1'b1;
      end else if (u2_ff) begin
         out_we    = 1'b1;
         out_waddr = {tgt_ff, i2_ff};
         out_wdata = onew;
      end

      err_we = u2_ff && !last_ff;
   end

   always_ff @(posedge clock) begin
      if (in_we) in_mem[in_waddr] <= in_wdata;
      in_q_ff <= in_mem[in_raddr];
   end

   always_ff @(posedge clock) begin
      if (out_we) out_mem[out_waddr] <= out_wdata;
      out_q_ff <= out_mem[out_raddr];
   end

   always_ff @(posedge clock) begin
      if (err_we) err_mem[i2_ff] <= enew;
      err_q_ff   <= err_mem[cnt_ff[EW-1:0]];
      err_v_q_ff <= err_vld_ff[cnt_ff[EW-1:0]];
   end

   // ---------------- datapath ----------------
   always_comb begin
      ushift  = acc_ff + CLAMP_F;
      mprod   = v_ff * sgns_pkg::SIG_RCP_W'(sgns_pkg::SIG_RCP);
      mq      = mprod[$bits(mprod)-1:sgns_pkg::SIG_RCP_SH];
      sig_val = hi_ff ? 17'h10000 : (lo_ff ? 17'h0 : {1'b0, rom_q_ff});
      diff    = (label_ff ? 18'sd65536 : 18'sd0) - $signed({1'b0, sig_val});
      gsum    = gprod_ff + 35'sd32768;

      ge_r = ge_ff + 34'sd2048;
      gx_r = gx_ff + 34'sd32768;
      esum = 33'(e2_ff) + 33'($signed(ge_r[33:12]));
      if (esum > 33'sd2147483647) begin
         enew = 32'sh7FFFFFFF;
      end else if (esum < -33'sd2147483648) begin
         enew = 32'sh80000000;
      end else begin
         enew = esum[31:0];
      end
      osum = 19'(o2_ff) + 19'($signed(gx_r[33:16]));
      if (osum > 19'sd32767) begin
         onew = 16'sh7FFF;
      end else if (osum < -19'sd32768) begin
         onew = 16'sh8000;
      end else begin
         onew = osum[15:0];
      end
      e3r  = 33'(enew3_ff) + 33'sd8;
      isum = 30'(x3_ff) + 30'($signed(e3r[32:4]));
      if (isum > 30'sd32767) begin
         inew = 16'sh7FFF;
      end else if (isum < -30'sd32768) begin
         inew = 16'sh8000;
      end else begin
         inew = isum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctx_ff   <= req_context_word;
         tgt_ff   <= req_target_word;
         label_ff <= req_label;
         lr_ff    <= req_learning_rate;
         last_ff  <= req_last_target;
         n_ff     <= (dim_used_ff > 8'(sgns_pkg::DIM)) ? CW'(sgns_pkg::DIM) : CW'(dim_used_ff);
         acc_ff   <= '0;
      end else if (d2_ff) begin
         acc_ff <= acc_ff + 40'(prod_ff);
      end
      prod_ff <= in_q_ff * out_q_ff;

      // clamp and table index
      hi_ff  <= (acc_ff >= CLAMP_F);
      lo_ff  <= (acc_ff < -CLAMP_F);
      v_ff   <= ushift[sgns_pkg::SIG_PRE_SH+sgns_pkg::SIG_V_W-1:sgns_pkg::SIG_PRE_SH];
      idx_ff <= (mq >= $bits(mq)'(sgns_pkg::SIG_N)) ? sgns_pkg::SIG_W'(sgns_pkg::SIG_N - 1)
                                                     : mq[sgns_pkg::SIG_W-1:0];

      // gradient: hold through the update pass
      if (state_ff == S_GRAD1) begin
         sig_ff   <= sig_val;
         gprod_ff <= diff * $signed({1'b0, lr_ff});
      end
      if (state_ff == S_GRAD2) g_ff <= gsum[33:16];

      // update pipeline
      i1_ff    <= cnt_ff[EW-1:0];
      i2_ff    <= i1_ff;
      i3_ff    <= i2_ff;
      ge_ff    <= g_ff * out_q_ff;
      gx_ff    <= g_ff * in_q_ff;
      x2_ff    <= in_q_ff;
      o2_ff    <= out_q_ff;
      e2_ff    <= err_v_q_ff ? err_q_ff : 32'sd0;
      x3_ff    <= x2_ff;
      enew3_ff <= enew;

      // response payload
      rsp_rd_ff      <= (state_ff == S_RD) ? in_q_ff : 16'sd0;
      rsp_score_ff   <= (state_ff != S_FIN) ? 16'h0000 :
                        (sig_ff[16] ? 16'hFFFF : sig_ff[15:0]);
      rsp_applied_ff <= (state_ff == S_FIN) && last_ff;
   end

`ifndef SYNTHESIS
   a_write_responds: assert property (@(posedge clock) disable iff (reset)
      (accept && (cmd == sgns_pkg::CMD_WR_IN || cmd == sgns_pkg::CMD_WR_OUT)) |=> rsp_valid)
      else $error("element write gave no response");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DOT || state_ff == S_UPD) |-> (cnt_ff <= n_ff))
      else $error("element counter ran past vector length");
   a_pipe_busy: assert property (@(posedge clock) disable iff (reset)
      (d1_ff || d2_ff || u1_ff || u2_ff || u3_ff) |-> busy)
      else $error("pipeline active while idle");
   a_applied_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_error_applied |-> rsp_valid)
      else $error("error_applied without response strobe");
   a_clear_after_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && last_ff) |=> (err_vld_ff == '0))
      else $error("accumulator not cleared after apply");
`endif

endmodule

// ===== sim/tb_skipgram_negative_sampling_update_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for skipgram_negative_sampling_update_top: drives element
// writes, reads and train requests and predicts every response. Depends on sgns_pkg.
module tb_skipgram_negative_sampling_update_top;

   localparam int MAX_CYCLES = 3000000;

   typedef struct {
      sgns_pkg::cmd_type  cmd;
      logic [15:0]        ctx;
      logic [15:0]        tgt;
      logic [6:0]         elem;
      logic signed [15:0] val;
      logic               label;
      logic [15:0]        lr;
      logic               last;
   } request_type;

   typedef struct {
      logic signed [15:0] read_value;
      logic [15:0]        score;
      logic               applied;
   } response_type;

   class sgns_scoreboard;
      shortint      in_mem[int];
      shortint      out_mem[int];
      longint       err_acc[sgns_pkg::DIM];
      int unsigned  sig_lut[sgns_pkg::SIG_N];
      int unsigned  dim_used;
      response_type pending_q[$];
      int           errors;

      function new();
         longint unsigned e1, ad, a, k, t, num, den;
         longint          d;
         errors   = 0;
         dim_used = 128;
         foreach (err_acc[i]) err_acc[i] = 0;
         e1 = exp_taylor(64'd1 << 30);
         for (int i = 0; i < sgns_pkg::SIG_N; i++) begin
            d   = 2 * longint'(i) - sgns_pkg::SIG_N;
            ad  = (d < 0) ? -d : d;
            a   = ((ad * sgns_pkg::CLAMP_RANGE) << 30) / sgns_pkg::SIG_N;
            k   = a >> 30;
            t   = exp_taylor(a & ((64'd1 << 30) - 1));
            for (longint unsigned j = 0; j < k; j++) t = (t * e1) >> 30;
            den = (64'd1 << 30) + t;
            num = (d >= 0) ? (64'd1 << 30) : t;
            sig_lut[i] = (((num << 16) + den / 2) / den > 65535) ? 65535 :
                         int'(((num << 16) + den / 2) / den);
         end
      endfunction

      // e^-y in Q2.30 for y in [0, 1]
      function longint unsigned exp_taylor(longint unsigned y);
         longint unsigned term;
         longint          sum;
         term = 64'd1 << 30;
         sum  = longint'(1) <<< 30;
         for (int n = 1; n <= 20; n++) begin
            term = ((term * y) >> 30) / n;
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         return (sum < 0) ? 0 : sum;
      endfunction

      function longint rnd(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return (v > hi) ? hi : (v < lo) ? lo : v;
      endfunction

      function void note(request_type r);
         response_type e;
         int           crow, trow;
         int unsigned  n;
         longint       f, sig, g, o, x, c24;
         e    = '{default: '0};
         crow = int'(r.ctx) * sgns_pkg::DIM;
         trow = int'(r.tgt) * sgns_pkg::DIM;
         case (r.cmd)
            sgns_pkg::CMD_WR_IN:  in_mem[crow + r.elem] = r.val;
            sgns_pkg::CMD_WR_OUT: out_mem[trow + r.elem] = r.val;
            sgns_pkg::CMD_RD_IN:  e.read_value = in_mem[crow + r.elem];
            sgns_pkg::CMD_TRAIN: begin
               n   = (dim_used > sgns_pkg::DIM) ? sgns_pkg::DIM : dim_used;
               f   = 0;
               c24 = longint'(sgns_pkg::CLAMP_RANGE) <<< 24;
               for (int c = 0; c < n; c++) f += in_mem[crow + c] * out_mem[trow + c];
               if (f >= c24) sig = 65536;
               else if (f < -c24) sig = 0;
               else sig = sig_lut[((f + c24) * sgns_pkg::SIG_N) / (2 * c24)];
               e.score = (sig > 65535) ? 16'hFFFF : sig[15:0];
               g = rnd((longint'(r.label) * 65536 - sig) * longint'(r.lr), 16);
               for (int c = 0; c < n; c++) begin
                  o = out_mem[trow + c];
                  x = in_mem[crow + c];
                  err_acc[c] = clip(err_acc[c] + rnd(g * o, 12), -(64'sd1 <<< 31),
                                    (64'sd1 <<< 31) - 1);
                  out_mem[trow + c] = shortint'(clip(o + rnd(g * x, 16), -32768, 32767));
               end
               if (r.last) begin
                  for (int c = 0; c < n; c++)
                     in_mem[crow + c] = shortint'(clip(in_mem[crow + c] +
                                                 rnd(err_acc[c], 4), -32768, 32767));
                  foreach (err_acc[i]) err_acc[i] = 0;
                  e.applied = 1'b1;
               end
            end
         endcase
         pending_q.push_back(e);
      endfunction

      task report(string what, longint got, longint want);
         $display("MISMATCH %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check(response_type got);
         response_type e;
         if (pending_q.size() == 0) begin
            report("unexpected response", 1, 0);
         end else begin
            e = pending_q.pop_front();
            if (got.read_value !== e.read_value)
               report("read_value", got.read_value, e.read_value);
            if (got.score !== e.score) report("score", got.score, e.score);
            if (got.applied !== e.applied) report("error_applied", got.applied, e.applied);
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd = '0;
   logic [15:0]        req_context_word = '0;
   logic [15:0]        req_target_word = '0;
   logic [6:0]         req_element = '0;
   logic signed [15:0] req_value = '0;
   logic               req_label = 1'b0;
   logic [15:0]        req_learning_rate = '0;
   logic               req_last_target = 1'b0;
   logic               rsp_valid;
   logic signed [15:0] rsp_read_value;
   logic [15:0]        rsp_score;
   logic               rsp_error_applied;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_data = '0;

   sgns_scoreboard sb = new();
   int             cycle_count = 0;
   logic [15:0]    ctx_rows[3] = '{16'd0, 16'd65535, 16'd777};
   logic [15:0]    tgt_rows[3] = '{16'd0, 16'd65535, 16'd4242};

   skipgram_negative_sampling_update_top u_dut (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_context_word, .req_target_word, .req_element, .req_value,
      .req_label, .req_learning_rate, .req_last_target,
      .rsp_valid, .rsp_read_value, .rsp_score, .rsp_error_applied,
      .csr_valid, .csr_ready, .csr_data
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check('{read_value: rsp_read_value, score: rsp_score,
                    applied: rsp_error_applied});
   end

   // keep start idle while a draw at the given chance comes up, then hold the request until taken
   task automatic send(request_type r, int gap_pct);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start             = 1'b1;
      req_cmd           = r.cmd;
      req_context_word  = r.ctx;
      req_target_word   = r.tgt;
      req_element       = r.elem;
      req_value         = r.val;
      req_label         = r.label;
      req_learning_rate = r.lr;
      req_last_target   = r.last;
      do @(posedge clock); while (busy);
      sb.note(r);
   endtask

   // drop start and wait until every response is in, plus a settle margin
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_dim(int unsigned v);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = v[7:0];
      do @(posedge clock); while (!csr_ready);
      sb.dim_used = v & 8'hFF;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic signed [15:0] pick_value();
      if ($urandom_range(7) == 0) return 16'($urandom);
      return 16'($urandom_range(1023)) - 16'sd512;
   endfunction

   function automatic request_type make_req(sgns_pkg::cmd_type cmd, logic [15:0] ctx,
                                            logic [15:0] tgt, logic [6:0] elem,
                                            logic signed [15:0] val);
      request_type r;
      r.cmd   = cmd;
      r.ctx   = ctx;
      r.tgt   = tgt;
      r.elem  = elem;
      r.val   = val;
      r.label = 1'($urandom);
      r.lr    = 16'($urandom);
      r.last  = 1'($urandom);
      return r;
   endfunction

   function automatic request_type random_req();
      request_type r;
      int          sel;
      int          key;
      sel = $urandom_range(99);
      r   = make_req(sgns_pkg::CMD_TRAIN, ctx_rows[$urandom_range(2)],
                     tgt_rows[$urandom_range(2)], 7'($urandom), pick_value());
      r.last = ($urandom_range(2) == 0);
      if (sel < 20) begin
         r.cmd = sgns_pkg::CMD_WR_IN;
         if ($urandom_range(3) == 0) r.ctx = 16'($urandom);
      end else if (sel < 38) begin
         r.cmd = sgns_pkg::CMD_WR_OUT;
         if ($urandom_range(3) == 0) r.tgt = 16'($urandom);
      end else if (sel < 52) begin
         r.cmd = sgns_pkg::CMD_RD_IN;
         // read back a written element of some other row when one turns up
         r.ctx = 16'($urandom);
         key   = int'(r.ctx) * sgns_pkg::DIM + r.elem;
         if (!sb.in_mem.exists(key)) r.ctx = ctx_rows[$urandom_range(2)];
      end
      return r;
   endfunction

   initial begin
      request_type r;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the training rows so that train never touches unwritten data
      foreach (ctx_rows[i])
         for (int e = 0; e < sgns_pkg::DIM; e++)
            send(make_req(sgns_pkg::CMD_WR_IN, ctx_rows[i], 16'($urandom), 7'(e),
                          pick_value()), 21);
      foreach (tgt_rows[i])
         for (int e = 0; e < sgns_pkg::DIM; e++)
            send(make_req(sgns_pkg::CMD_WR_OUT, 16'($urandom), tgt_rows[i], 7'(e),
                          pick_value()), 21);

      // directed: field extremes, both labels, rate extremes, context change
      send(make_req(sgns_pkg::CMD_WR_IN, 16'd12345, 16'd0, 7'd0, 16'sh7FFF), 0);
      send(make_req(sgns_pkg::CMD_WR_IN, 16'd12345, 16'd0, 7'd127, -16'sh8000), 0);
      send(make_req(sgns_pkg::CMD_RD_IN, 16'd12345, 16'd0, 7'd0, 16'sd0), 0);
      send(make_req(sgns_pkg::CMD_RD_IN, 16'd12345, 16'd0, 7'd127, 16'sd0), 0);
      send(make_req(sgns_pkg::CMD_RD_IN, 16'd65535, 16'hFFFF, 7'd127, -16'sd1), 0);
      r = make_req(sgns_pkg::CMD_TRAIN, 16'd0, 16'd0, 7'd0, 16'sd0);
      r.label = 1'b1; r.lr = 16'hFFFF; r.last = 1'b0;
      send(r, 0);
      r.ctx = 16'd777; r.tgt = 16'd65535; r.label = 1'b0; r.lr = 16'h0000;
      send(r, 0);
      r.ctx = 16'd65535; r.tgt = 16'd4242; r.label = 1'b0; r.lr = 16'hFFFF; r.last = 1'b1;
      send(r, 0);
      r.label = 1'b1; r.lr = 16'h8000;
      send(r, 0);
      write_dim(0);
      send(r, 0);
      write_dim(1);
      r.ctx = 16'd0; r.last = 1'b0;
      send(r, 0);
      r.last = 1'b1;
      send(r, 0);
      write_dim(255);
      send(r, 0);
      send(make_req(sgns_pkg::CMD_RD_IN, 16'd0, 16'd0, 7'd3, 16'sd0), 0);

      write_dim(128);
      repeat (360) send(random_req(), 21);
      write_dim($urandom_range(2, 127));
      repeat (360) send(random_req(), 72);
      write_dim(255);
      repeat (360) send(random_req(), 0);

      drain();
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== skipgram_negative_sampling_update_top.f =====
design/sgns_pkg.sv
design/sgns_sig_rom.sv
design/skipgram_negative_sampling_update_top.sv
sim/tb_skipgram_negative_sampling_update_top.sv
